// File: design/ppg_skin_contact_detector_top_assert.svh
// Assertion macros for the skin-contact detector checker.
`ifndef PPG_SKIN_CONTACT_DETECTOR_TOP_ASSERT_SVH
`define PPG_SKIN_CONTACT_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPGSCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPGSCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ppgscd_pkg.sv
`default_nettype none

package ppgscd_pkg;

	// Field and state widths
	localparam int IR_W   = 24;
	localparam int TS_W   = 32;
	localparam int DC_W   = 32;
	localparam int AC_W   = 34;
	localparam int ACT_W  = 33;
	localparam int MS_W   = 56;
	localparam int EXT_W  = 58;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;
	localparam int SUM_W  = 96;
	localparam int RUN_W  = 4;
	localparam int MS_FRAC = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int THR_W      = 24;
	localparam int IBI_W      = 16;
	localparam int BTC_W      = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_DC_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BEAT_INTERVAL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BEAT_INTERVAL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BEATS_TO_CONFIRM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VALIDITY_TIMEOUT     = 3'd4;

	localparam logic [THR_W-1:0] THR_RESET     = 24'd5000;
	localparam logic [IBI_W-1:0] MIN_IBI_RESET = 16'd333;
	localparam logic [IBI_W-1:0] MAX_IBI_RESET = 16'd1500;
	localparam logic [BTC_W-1:0] BTC_RESET     = 4'd2;
	localparam logic [IBI_W-1:0] TIMEOUT_RESET = 16'd6000;

	localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SCALE,
		ST_APPLY,
		ST_CHECK,
		ST_SQ_ABS,
		ST_SQ_MUL,
		ST_PK_MUL,
		ST_PK_DEC
	} state_t;

	typedef enum logic [1:0] {
		FLT_DC,
		FLT_AC,
		FLT_MS
	} flt_t;

endpackage

`default_nettype wire

// File: design/ppgscd_in_if.sv
`default_nettype none

interface ppgscd_in_if;
	import ppgscd_pkg::*;

	logic            valid;
	logic            ready;
	logic [IR_W-1:0] ir_raw;
	logic [TS_W-1:0] timestamp_ms;

	modport source (output valid, output ir_raw, output timestamp_ms, input ready);
	modport sink (input valid, input ir_raw, input timestamp_ms, output ready);
endinterface

`default_nettype wire

// File: design/ppgscd_out_if.sv
`default_nettype none

interface ppgscd_out_if;
	logic valid;
	logic ready;
	logic skin_valid;
	logic contact_present;
	logic beat_detected;

	modport source (output valid, output skin_valid, output contact_present,
		output beat_detected, input ready);
	modport sink (input valid, input skin_valid, input contact_present,
		input beat_detected, output ready);
endinterface

`default_nettype wire

// File: design/ppg_skin_contact_detector_top.sv
// PPG skin-contact detector.
// Channels: "sample" takes one IR reflectance sample with its millisecond
// timestamp per transfer; "result" delivers one result per sample:
// skin_valid, contact_present and beat_detected. Both use valid/ready; a
// transfer happens when both are high at a rising clock edge.
// Configuration: cfg_write with cfg_index/cfg_data writes one register per
// cycle; write only while the block is idle.
// Datapath: one shared 32x32 multiplier and one wide adder run three IIR
// filters in turn (five steps each) plus the square and peak products.
// A sample with contact runs all three filters, one without contact only the
// DC filter; sample ready returns in the cycle the result appears, so a new
// sample is taken only once the previous one's result has been loaded.
// Sample ready is high only while the sequencer is idle.
// Stall: the result sits in an output register; a new sample is taken while
// it waits, and the sequencer holds at its last step until the slot frees.
// Reset (arst_n low): filters, beat history and validation clear to zero,
// registers return to their defaults, no result is pending.
`default_nettype none

module ppg_skin_contact_detector_top #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	ppgscd_in_if.sink                               sample,
	ppgscd_out_if.source                            result,
	input  wire logic                               cfg_write,
	input  wire logic [ppgscd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ppgscd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ppgscd_pkg::*;

	// Sample width actually seen, and the filter coefficients
	localparam int IN_BITS = (SAMPLE_BITS < IR_W) ? SAMPLE_BITS : IR_W;
	localparam logic [IR_W-1:0] SAMPLE_MASK = IR_W'((64'd1 << IN_BITS) - 64'd1);
	localparam logic [MUL_W-1:0] DC_COEF =
		MUL_W'(((64'd1 << COEF_FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [MUL_W-1:0] AC_COEF =
		MUL_W'((64'd3 * (64'd1 << COEF_FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [SUM_W-1:0] HALF = SUM_W'(64'd1 << (COEF_FRAC_BITS - 1));
	localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

	// Configuration registers
	logic [THR_W-1:0] thr_q;
	logic [IBI_W-1:0] min_ibi_q;
	logic [IBI_W-1:0] max_ibi_q;
	logic [BTC_W-1:0] btc_q;
	logic [IBI_W-1:0] timeout_q;

	// Detector state
	logic        [DC_W-1:0]  dc_q;
	logic signed [AC_W-1:0]  ac_q;
	logic signed [AC_W-1:0]  ac_prev_q;
	logic signed [AC_W-1:0]  ac_bprev_q;
	logic        [MS_W-1:0]  ms_q;
	logic        [TS_W-1:0]  last_peak_q;
	logic        [TS_W-1:0]  last_valid_q;
	logic        [RUN_W-1:0] run_q;
	logic                    skin_q;

	// Sequencer
	state_t state_q, state_d;
	flt_t   flt_q;

	// Working registers of the shared unit
	logic        [DC_W-1:0]   x_q;
	logic        [TS_W-1:0]   now_q;
	logic signed [ACT_W-1:0]  ac_tgt_q;
	logic        [MS_W-1:0]   mag_q;
	logic                     neg_q;
	logic        [PROD_W-1:0] prod_lo_q;
	logic        [PROD_W-1:0] prod_hi_q;
	logic        [MS_W-1:0]   step_q;
	logic        [ACT_W-1:0]  amag_q;
	logic        [MS_W-1:0]   sq_q;
	logic                     pk_cand_q;

	// Output register
	logic out_valid_q;
	logic out_skin_q;
	logic out_contact_q;
	logic out_beat_q;

	// Combinational datapath
	logic signed [EXT_W-1:0]  cur_ext;
	logic signed [EXT_W-1:0]  tgt_ext;
	logic signed [EXT_W-1:0]  diff_up;
	logic signed [EXT_W-1:0]  diff_dn;
	logic signed [EXT_W-1:0]  step_ext;
	logic signed [EXT_W-1:0]  new_ext;
	logic                     tgt_ge;
	logic        [MUL_W-1:0]  mul_a;
	logic        [MUL_W-1:0]  mul_b;
	logic        [PROD_W-1:0] mul_p;
	logic        [MUL_W-1:0]  coef_sel;
	logic        [SUM_W-1:0]  scale_sum;
	logic                     contact;
	logic                     slot_free;
	logic                     load_res;
	logic                     peak;
	logic        [TS_W-1:0]   ibi;
	logic                     ibi_ok;
	logic        [RUN_W-1:0]  run_inc;
	logic                     skin_next;

	assign slot_free = !out_valid_q || result.ready;
	assign contact   = dc_q >= {thr_q, 8'b0};

	// Select the filter the shared unit works on
	always_comb begin
		case (flt_q)
			FLT_DC: begin
				cur_ext = {{(EXT_W-DC_W){1'b0}}, dc_q};
				tgt_ext = {{(EXT_W-DC_W){1'b0}}, x_q};
			end
			FLT_AC: begin
				cur_ext = {{(EXT_W-AC_W){ac_q[AC_W-1]}}, ac_q};
				tgt_ext = {{(EXT_W-ACT_W){ac_tgt_q[ACT_W-1]}}, ac_tgt_q};
			end
			default: begin
				cur_ext = {{(EXT_W-MS_W){1'b0}}, ms_q};
				tgt_ext = {{(EXT_W-MS_W){1'b0}}, sq_q};
			end
		endcase
		coef_sel = (flt_q == FLT_AC) ? AC_COEF : DC_COEF;
	end

	assign tgt_ge   = tgt_ext >= cur_ext;
	assign diff_up  = tgt_ext - cur_ext;
	assign diff_dn  = cur_ext - tgt_ext;
	assign step_ext = {{(EXT_W-MS_W){1'b0}}, step_q};
	assign new_ext  = neg_q ? (cur_ext - step_ext) : (cur_ext + step_ext);

	// Shared multiplier
	always_comb begin
		case (state_q)
			ST_MUL_LO: begin
				mul_a = mag_q[MUL_W-1:0];
				mul_b = coef_sel;
			end
			ST_MUL_HI: begin
				mul_a = {{(2*MUL_W-MS_W){1'b0}}, mag_q[MS_W-1:MUL_W]};
				mul_b = coef_sel;
			end
			ST_SQ_MUL: begin
				mul_a = amag_q[MUL_W-1:0];
				mul_b = amag_q[MUL_W-1:0];
			end
			ST_PK_MUL: begin
				mul_a = ac_prev_q[MUL_W-1:0];
				mul_b = ac_prev_q[MUL_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Rounded scaling: (mag * coef + half) >> F
	assign scale_sum = {prod_hi_q, {MUL_W{1'b0}}} + {{(SUM_W-PROD_W){1'b0}}, prod_lo_q} + HALF;

	// Peak decision and interval bookkeeping
	always_comb begin
		peak    = pk_cand_q && (ac_prev_q[MUL_W] || (prod_lo_q > {ms_q, 8'b0}));
		ibi     = now_q - last_peak_q;
		ibi_ok  = (ibi >= {{(TS_W-IBI_W){1'b0}}, min_ibi_q})
			&& (ibi <= {{(TS_W-IBI_W){1'b0}}, max_ibi_q});
		run_inc = (run_q == RUN_MAX) ? RUN_MAX : run_q + RUN_W'(1);
		skin_next = skin_q || (peak && ibi_ok && (run_inc >= btc_q));
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_res = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_d = ST_DIFF;
			end
			ST_DIFF:   state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_APPLY;
			ST_APPLY: begin
				case (flt_q)
					FLT_DC:  state_d = ST_CHECK;
					FLT_AC:  state_d = ST_SQ_ABS;
					default: state_d = ST_PK_MUL;
				endcase
			end
			ST_CHECK: begin
				if (contact) begin
					state_d = ST_DIFF;
				end else if (slot_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SQ_ABS: state_d = ST_SQ_MUL;
			ST_SQ_MUL: state_d = ST_DIFF;
			ST_PK_MUL: state_d = ST_PK_DEC;
			ST_PK_DEC: begin
				if (slot_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sample.ready = (state_q == ST_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			min_ibi_q <= MIN_IBI_RESET;
			max_ibi_q <= MAX_IBI_RESET;
			btc_q     <= BTC_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CONTACT_DC_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				CFG_MIN_BEAT_INTERVAL:    min_ibi_q <= cfg_data[IBI_W-1:0];
				CFG_MAX_BEAT_INTERVAL:    max_ibi_q <= cfg_data[IBI_W-1:0];
				CFG_BEATS_TO_CONFIRM:     btc_q     <= cfg_data[BTC_W-1:0];
				CFG_VALIDITY_TIMEOUT:     timeout_q <= cfg_data[IBI_W-1:0];
				default: ;
			endcase
		end
	end

	// Detector state and filter select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flt_q        <= FLT_DC;
			dc_q         <= '0;
			ac_q         <= '0;
			ac_prev_q    <= '0;
			ac_bprev_q   <= '0;
			ms_q         <= '0;
			last_peak_q  <= '0;
			last_valid_q <= '0;
			run_q        <= '0;
			skin_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					flt_q <= FLT_DC;
				end
				ST_APPLY: begin
					case (flt_q)
						FLT_DC:  dc_q <= new_ext[DC_W-1:0];
						FLT_AC:  ac_q <= new_ext[AC_W-1:0];
						default: ms_q <= new_ext[MS_W-1:0];
					endcase
				end
				ST_CHECK: begin
					if (contact) begin
						flt_q <= FLT_AC;
						// lapse validation when no valid beat came in time
						if (skin_q && ((now_q - last_valid_q) >
							{{(TS_W-IBI_W){1'b0}}, timeout_q})) begin
							skin_q <= 1'b0;
						end
					end else if (slot_free) begin
						// nothing on the sensor: drop the pulse history except the peak timestamps
						ac_q       <= '0;
						ac_prev_q  <= '0;
						ac_bprev_q <= '0;
						ms_q       <= '0;
						run_q      <= '0;
						skin_q     <= 1'b0;
					end
				end
				ST_SQ_MUL: begin
					flt_q <= FLT_MS;
				end
				ST_PK_DEC: begin
					if (slot_free) begin
						ac_bprev_q <= ac_prev_q;
						ac_prev_q  <= ac_q;
						skin_q     <= skin_next;
						if (peak) begin
							last_peak_q <= now_q;
							if (ibi_ok) begin
								run_q        <= run_inc;
								last_valid_q <= now_q;
							end else begin
								run_q <= '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					x_q   <= {sample.ir_raw & SAMPLE_MASK, {MS_FRAC{1'b0}}};
					now_q <= sample.timestamp_ms;
				end
			end
			ST_DIFF: begin
				neg_q <= !tgt_ge;
				mag_q <= tgt_ge ? diff_up[MS_W-1:0] : diff_dn[MS_W-1:0];
			end
			ST_MUL_LO: prod_lo_q <= mul_p;
			ST_MUL_HI: prod_hi_q <= mul_p;
			ST_SCALE:  step_q <= MS_W'(scale_sum >> COEF_FRAC_BITS);
			ST_CHECK: begin
				ac_tgt_q <= $signed({1'b0, x_q}) - $signed({1'b0, dc_q});
			end
			ST_SQ_ABS: begin
				amag_q    <= ac_q[AC_W-1] ? ACT_W'(-ac_q) : ac_q[ACT_W-1:0];
				pk_cand_q <= (ac_prev_q > ac_bprev_q) && (ac_prev_q > ac_q)
					&& !ac_prev_q[AC_W-1] && (ac_prev_q != '0);
			end
			ST_SQ_MUL: begin
				// square in counts^2 * 256, saturated when the magnitude overflows
				sq_q <= amag_q[MUL_W] ? MS_MAX : mul_p[PROD_W-1:MS_FRAC];
			end
			ST_PK_MUL: prod_lo_q <= mul_p;
			default: ;
		endcase
	end

	// Output register: hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			if (state_q == ST_PK_DEC) begin
				out_skin_q    <= skin_next;
				out_contact_q <= 1'b1;
				out_beat_q    <= peak;
			end else begin
				out_skin_q    <= 1'b0;
				out_contact_q <= 1'b0;
				out_beat_q    <= 1'b0;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.skin_valid      = out_skin_q;
	assign result.contact_present = out_contact_q;
	assign result.beat_detected   = out_beat_q;

endmodule

`default_nettype wire

// File: design/ppgscd_checker.sv
`default_nettype none

`include "ppg_skin_contact_detector_top_assert.svh"

module ppgscd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	input wire logic sample_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic skin_valid,
	input wire logic contact_present,
	input wire logic beat_detected
);

	`PPGSCD_ASSERT_IMP(a_no_contact_quiet, clk, arst_n, result_valid && !contact_present, !beat_detected && !skin_valid, "beat or skin reported without contact")

	`PPGSCD_ASSERT_NXT(a_busy_after_take, clk, arst_n, sample_valid && sample_ready, !sample_ready, "sample ready right after a transfer")

	`PPGSCD_ASSERT_NXT(a_no_instant_result, clk, arst_n, sample_valid && sample_ready, !$rose(result_valid), "result appeared one cycle after a sample")

	`PPGSCD_ASSERT_NXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(skin_valid) && $stable(contact_present) && $stable(beat_detected), "stalled result changed")

endmodule

bind ppg_skin_contact_detector_top ppgscd_checker u_ppgscd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.sample_valid    (sample.valid),
	.sample_ready    (sample.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.skin_valid      (result.skin_valid),
	.contact_present (result.contact_present),
	.beat_detected   (result.beat_detected)
);

`default_nettype wire
